FILE: hdl/stratified_sample_disk_warp_macros.svh
// Assertion macros shared by the stratified sample disk warp design.
`ifndef STRATIFIED_SAMPLE_DISK_WARP_MACROS_SVH
`define STRATIFIED_SAMPLE_DISK_WARP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SSDW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold whenever the enabling condition holds.
`define SSDW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/ssdw_pkg.sv
// ----------------------------------------------------------------------------
// Stratified sample disk warp package
// Shared types, register indexes, constants and the pipeline step functions.
// ----------------------------------------------------------------------------
package ssdw_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES  = 17;

  localparam logic [1:0] MODE_RANDOM = 2'd0;
  localparam logic [1:0] MODE_CENTRE = 2'd1;
  localparam logic [1:0] MODE_JITTER = 2'd2;

  localparam logic [1:0] REG_SAMPLE_MODE = 2'd0;
  localparam logic [1:0] REG_WARP_MODE   = 2'd1;
  localparam logic [1:0] REG_GRID_SIDE   = 2'd2;

  localparam logic [29:0] GAIN_Q30 = 30'd652032875;
  localparam logic [15:0] HALF_FRAC = 16'h8000;
  localparam logic [15:0] QUARTER_Q15 = 16'd16384;

  localparam logic signed [33:0] ARC_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004757,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
  };

  typedef struct packed {
    logic [15:0] sample_index;
    logic [15:0] jitter_x;
    logic [15:0] jitter_y;
    logic [15:0] rand_x;
    logic [15:0] rand_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
  } out_t;

  typedef struct packed {
    logic [15:0]        idx;
    logic [15:0]        row;
    logic [8:0]         rem;
    logic [15:0]        fx;
    logic [15:0]        fy;
    logic [8:0]         rx;
    logic [8:0]         ry;
    logic [15:0]        qx;
    logic [15:0]        qy;
    logic               ovr;
    logic [15:0]        rand_x;
    logic [15:0]        rand_y;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [31:0]        sq_n;
    logic [17:0]        sq_r;
    logic [15:0]        sq_q;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] dz;
    logic               flip;
  } stage_t;

  // One restoring division step: returns the quotient bit and new remainder.
  function automatic logic [9:0] div_step(input logic [8:0] r, input logic b,
                                          input logic [8:0] side);
    logic [9:0] t;
    logic [9:0] d;
    begin
      t = {r, b};
      d = t - {1'b0, side};
      if (t >= {1'b0, side}) begin
        div_step = {1'b1, d[8:0]};
      end else begin
        div_step = {1'b0, t[8:0]};
      end
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    begin
      if (v > 20'sd32767) begin
        sat16 = 16'sh7fff;
      end else if (v < -20'sd32768) begin
        sat16 = 16'sh8000;
      end else begin
        sat16 = v[15:0];
      end
    end
  endfunction

  // Work of pipeline stage k: index division, coordinate division, square
  // root, gain and angle reduction, then rotations.
  function automatic stage_t stage_fn(input int k, input stage_t s_in,
                                      input logic [8:0] side, input logic [1:0] smode);
    stage_t s;
    logic [9:0] dr;
    logic [18:0] tr;
    logic [18:0] tt;
    logic [45:0] prod;
    logic [31:0] a;
    logic signed [33:0] sx_sh;
    logic signed [33:0] sy_sh;
    int i;
    begin
      s = s_in;
      if (k < 4) begin
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          dr = div_step(s.rem, s.idx[15], side);
          s.idx = {s.idx[14:0], 1'b0};
          s.rem = dr[8:0];
          s.row = {s.row[14:0], dr[9]};
        end
        if (k == 3) begin
          s.rx  = s.rem;
          s.ovr = (s.row >= {7'd0, side});
          s.ry  = s.row[8:0];
        end
      end else if (k < 8) begin
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          dr = div_step(s.rx, s.fx[15], side);
          s.rx = dr[8:0];
          s.qx = {s.qx[14:0], dr[9]};
          s.fx = {s.fx[14:0], 1'b0};
          dr = div_step(s.ry, s.fy[15], side);
          s.ry = dr[8:0];
          s.qy = {s.qy[14:0], dr[9]};
          s.fy = {s.fy[14:0], 1'b0};
        end
        if (k == 7) begin
          if (smode == MODE_RANDOM) begin
            s.sx = s.rand_x;
            s.sy = s.rand_y;
          end else begin
            s.sx = s.qx;
            s.sy = s.ovr ? 16'hffff : s.qy;
          end
          s.cx   = {1'b0, s.sx[15:1]} - QUARTER_Q15;
          s.cy   = {1'b0, s.sy[15:1]} - QUARTER_Q15;
          s.sq_n = {s.sx, 16'd0};
          s.sq_r = '0;
          s.sq_q = '0;
        end
      end else if (k < 12) begin
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          tr = {s.sq_r[16:0], s.sq_n[31:30]};
          tt = {1'b0, s.sq_q, 2'b01};
          s.sq_n = {s.sq_n[29:0], 2'b00};
          if (tr >= tt) begin
            s.sq_r = 18'(tr - tt);
            s.sq_q = {s.sq_q[14:0], 1'b1};
          end else begin
            s.sq_r = tr[17:0];
            s.sq_q = {s.sq_q[14:0], 1'b0};
          end
        end
      end else if (k == 12) begin
        prod = 46'(s.sq_q) * 46'(GAIN_Q30);
        s.dx = 34'(prod[45:16]);
        s.dy = '0;
        a = {s.sy, 16'd0};
        s.flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (s.flip) begin
          a = a ^ 32'h8000_0000;
        end
        s.dz = 34'(signed'(a));
      end else begin
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
          i = (k - 13) * STEPS_PER_STAGE + j;
          sx_sh = s.dy >>> i;
          sy_sh = s.dx >>> i;
          if (!s.dz[33]) begin
            s.dx = s.dx - sx_sh;
            s.dy = s.dy + sy_sh;
            s.dz = s.dz - ARC_TURNS[i];
          end else begin
            s.dx = s.dx + sx_sh;
            s.dy = s.dy - sy_sh;
            s.dz = s.dz + ARC_TURNS[i];
          end
        end
      end
      stage_fn = s;
    end
  endfunction

endpackage

FILE: hdl/stratified_sample_disk_warp.sv
// ----------------------------------------------------------------------------
// Stratified sample disk warp
// Streams stratified square samples, centred or warped onto the unit disk.
// ----------------------------------------------------------------------------
// Input transactions carry a sample index and four Q0.16 fractions on in_data
// under in_valid and in_ready; results leave as two Q1.15 values on out_data
// under out_valid and out_ready. Registers are written on the cfg channel,
// which is always ready, and should only be changed while the block is idle.
// Each transaction is registered on entry when it is accepted, then passes
// four index division stages, four coordinate division stages, four square
// root stages, one gain multiply stage and four rotation stages, with the
// division, square root and rotation stages each doing four iterations,
// and finally reaches out_valid in the output register.
// One transaction is accepted every cycle while the output is taken.
// Reset empties the pipeline and returns the registers to grid cell centre
// sampling, square centring and a grid side of one.
// When the receiver stalls, the whole pipeline holds and in_ready falls, so
// no transaction is lost or repeated.
// ----------------------------------------------------------------------------
`include "stratified_sample_disk_warp_macros.svh"

module stratified_sample_disk_warp (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssdw_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ssdw_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data
);

  logic [1:0] sample_mode;
  logic       warp_mode;
  logic [8:0] grid_side;
  logic [8:0] side;
  logic       en;

  ssdw_pkg::stage_t pipe  [ssdw_pkg::NUM_STAGES+1];
  logic             vld   [ssdw_pkg::NUM_STAGES+1];
  ssdw_pkg::stage_t entry;
  ssdw_pkg::out_t   result_next;
  logic signed [19:0] ox;
  logic signed [19:0] oy;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode <= ssdw_pkg::MODE_CENTRE;
      warp_mode   <= 1'b0;
      grid_side   <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssdw_pkg::REG_SAMPLE_MODE: sample_mode <= cfg_data[1:0];
        ssdw_pkg::REG_WARP_MODE:   warp_mode   <= cfg_data[0];
        ssdw_pkg::REG_GRID_SIDE:   grid_side   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_side == 9'd0) begin
      side = 9'd1;
    end else if (grid_side > 9'(ssdw_pkg::MAX_SIDE)) begin
      side = 9'(ssdw_pkg::MAX_SIDE);
    end else begin
      side = grid_side;
    end
  end

  always_comb begin
    entry        = '0;
    entry.idx    = in_data.sample_index;
    entry.rand_x = in_data.rand_x;
    entry.rand_y = in_data.rand_y;
    if (sample_mode == ssdw_pkg::MODE_JITTER) begin
      entry.fx = in_data.jitter_x;
      entry.fy = in_data.jitter_y;
    end else begin
      entry.fx = ssdw_pkg::HALF_FRAC;
      entry.fy = ssdw_pkg::HALF_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= entry;
    end
  end

  for (genvar k = 0; k < ssdw_pkg::NUM_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k+1] <= ssdw_pkg::stage_fn(k, pipe[k], side, sample_mode);
      end
    end
  end

  always_comb begin
    ox = 20'(pipe[ssdw_pkg::NUM_STAGES].dx >>> 15);
    oy = 20'(pipe[ssdw_pkg::NUM_STAGES].dy >>> 15);
    if (pipe[ssdw_pkg::NUM_STAGES].flip) begin
      ox = -ox;
      oy = -oy;
    end
    if (warp_mode) begin
      result_next.out_x = ssdw_pkg::sat16(ox);
      result_next.out_y = ssdw_pkg::sat16(oy);
    end else begin
      result_next.out_x = pipe[ssdw_pkg::NUM_STAGES].cx;
      result_next.out_y = pipe[ssdw_pkg::NUM_STAGES].cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ssdw_pkg::NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= result_next;
    end
  end

  `SSDW_ASSERT_IMPLY(a_sqrt_rem, vld[12], pipe[12].sq_r <= {1'b0, pipe[12].sq_q, 1'b0}, "square root remainder out of range")
  `SSDW_ASSERT_IMPLY(a_angle_range, vld[13], (pipe[13].dz >= -34'sd1073741824) && (pipe[13].dz < 34'sd1073741824), "reduced angle outside half turn")
  `SSDW_ASSERT_ALWAYS(a_ready_tracks, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

endmodule

FILE: bench/ssdw_checker.sv
// ----------------------------------------------------------------------------
// Stratified sample disk warp checker
// Follows the register writes and input transactions of the block. For each
// accepted input it computes the expected sample position. Each result is
// compared, field by field, with the oldest expected position.
// ----------------------------------------------------------------------------
module ssdw_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ssdw_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ssdw_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [8:0]     cfg_data,
  output int             errors,
  output int             outstanding
);

  logic [1:0]     smode_q;
  logic           wmode_q;
  logic [8:0]     side_q;
  ssdw_pkg::out_t positions_due[$];
  int             results_seen;

  localparam longint signed ARC_TBL [16] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
  };

  function automatic longint unsigned grid_coord(longint unsigned slot,
                                                 longint unsigned f,
                                                 longint unsigned side);
    longint unsigned q;
    q = ((slot << 16) + f) / side;
    return (q > 65535) ? 65535 : q;
  endfunction

  function automatic logic [15:0] clamp_q15(longint signed v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= n) r = r + (64'd1 << b);
    end
    return r;
  endfunction

  function automatic ssdw_pkg::out_t disk_point(longint unsigned sx, longint unsigned sy);
    ssdw_pkg::out_t  o;
    longint unsigned r30;
    longint unsigned a;
    logic            flip;
    longint signed   x;
    longint signed   y;
    longint signed   z;
    longint signed   dx;
    longint signed   dy;
    r30 = root_floor(sx << 16) << 14;
    a = (sy << 16) & 64'hFFFF_FFFF;
    flip = 1'b0;
    if (a >= (64'd1 << 30) && a < (64'd3 << 30)) begin
      a = (a - (64'd1 << 31)) & 64'hFFFF_FFFF;
      flip = 1'b1;
    end
    z = (a >= (64'd1 << 31)) ? longint'(a) - (64'sd1 <<< 32) : longint'(a);
    x = longint'((r30 * 64'd652032875) >> 30);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TBL[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TBL[i];
      end
    end
    x = x >>> 15;
    y = y >>> 15;
    if (flip) begin
      x = -x;
      y = -y;
    end
    o.out_x = clamp_q15(x);
    o.out_y = clamp_q15(y);
    return o;
  endfunction

  function automatic ssdw_pkg::out_t sample_position(ssdw_pkg::in_t d);
    ssdw_pkg::out_t  o;
    longint unsigned side;
    longint unsigned col;
    longint unsigned row;
    longint unsigned sx;
    longint unsigned sy;
    side = side_q;
    if (side == 0) side = 1;
    if (side > ssdw_pkg::MAX_SIDE) side = ssdw_pkg::MAX_SIDE;
    col = d.sample_index % side;
    row = d.sample_index / side;
    if (smode_q == ssdw_pkg::MODE_RANDOM) begin
      sx = d.rand_x;
      sy = d.rand_y;
    end else if (smode_q == ssdw_pkg::MODE_JITTER) begin
      sx = grid_coord(col, d.jitter_x, side);
      sy = grid_coord(row, d.jitter_y, side);
    end else begin
      sx = grid_coord(col, 32768, side);
      sy = grid_coord(row, 32768, side);
    end
    if (!wmode_q) begin
      o.out_x = clamp_q15(longint'(sx >> 1) - 16384);
      o.out_y = clamp_q15(longint'(sy >> 1) - 16384);
    end else begin
      o = disk_point(sx, sy);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s is %0d, expected %0d",
             results_seen, what, got, want);
    errors++;
  endtask

  assign outstanding = positions_due.size();

  initial errors = 0;
  initial results_seen = 0;

  always @(posedge clk) begin
    ssdw_pkg::out_t want;
    if (rst) begin
      smode_q <= ssdw_pkg::MODE_CENTRE;
      wmode_q <= 1'b0;
      side_q  <= 9'd1;
      positions_due.delete();
    end else begin
      if (in_valid && in_ready) positions_due.push_back(sample_position(in_data));
      if (out_valid && out_ready) begin
        if (positions_due.size() == 0) begin
          $display("unexpected result %0d with no input outstanding", results_seen);
          errors++;
        end else begin
          want = positions_due.pop_front();
          if (out_data.out_x !== want.out_x)
            report_mismatch("out_x", out_data.out_x, want.out_x);
          if (out_data.out_y !== want.out_y)
            report_mismatch("out_y", out_data.out_y, want.out_y);
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ssdw_pkg::REG_SAMPLE_MODE: smode_q <= cfg_data[1:0];
          ssdw_pkg::REG_WARP_MODE:   wmode_q <= cfg_data[0];
          ssdw_pkg::REG_GRID_SIDE:   side_q  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Stratified sample disk warp testbench
// Steps through many register settings. Each setting gets a few directed
// samples at the grid and angle boundaries, then random samples. The input
// arrives in bursts and the output stalls on its own pattern. A checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 500000;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  ssdw_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  ssdw_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [8:0]     cfg_data;
  int             errors;
  int             outstanding;
  int             cycles;
  int             burst_left;
  int             stall_left;
  int             samples_sent;
  int             settings_done;

  stratified_sample_disk_warp dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ssdw_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b0;
          stall_left <= $urandom_range(0, 6);
        end
        1: begin
          out_ready <= 1'b1;
          stall_left <= $urandom_range(20, 80);
        end
        default: begin
          out_ready <= $urandom_range(0, 1);
          stall_left <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(logic [1:0] smode, logic wmode, logic [8:0] side);
    write_reg(ssdw_pkg::REG_SAMPLE_MODE, {7'($urandom_range(0, 127)), smode});
    write_reg(ssdw_pkg::REG_WARP_MODE, {8'($urandom_range(0, 255)), wmode});
    write_reg(ssdw_pkg::REG_GRID_SIDE, side);
    write_reg(REG_SPARE, 9'($urandom_range(0, 511)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(ssdw_pkg::in_t d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic run_setting(logic [1:0] smode, logic wmode, logic [8:0] side,
                             int count);
    ssdw_pkg::in_t   d;
    int              eff;
    int              cells;
    logic [15:0]     edges[6];
    apply_setting(smode, wmode, side);
    eff = (side == 0) ? 1 :
          ((side > ssdw_pkg::MAX_SIDE) ? ssdw_pkg::MAX_SIDE : side);
    cells = eff * eff;
    edges = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000, 16'h3FFF};
    for (int k = 0; k < 6; k++) begin
      d.sample_index = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF :
                       (k == 2) ? 16'(cells - 1) : (k == 3) ? 16'(cells) :
                       16'($urandom_range(0, cells - 1));
      d.jitter_x = edges[k];
      d.jitter_y = edges[5 - k];
      d.rand_x   = edges[(k + 1) % 6];
      d.rand_y   = edges[k];
      send_sample(d);
    end
    for (int n = 0; n < count; n++) begin
      d = 80'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 9) != 0)
        d.sample_index = 16'($urandom_range(0, (cells > 65536 ? 65536 : cells) - 1));
      send_sample(d);
    end
    drain();
    settings_done++;
  endtask

  initial begin
    logic [8:0] sides[10];
    rst = 1'b1;
    cycles = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ssdw_pkg::REG_SAMPLE_MODE;
    cfg_data = '0;
    burst_left = 0;
    stall_left = 0;
    samples_sent = 0;
    settings_done = 0;
    sides = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd7, 9'd16, 9'd100, 9'd255, 9'd256, 9'd511};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int m = 0; m < 4; m++) begin
      for (int w = 0; w < 2; w++) begin
        run_setting(2'(m), w[0], sides[$urandom_range(0, 9)], 40);
      end
    end
    for (int s = 0; s < 10; s++) begin
      run_setting(ssdw_pkg::MODE_JITTER, s[0], sides[s], 70);
      run_setting(2'($urandom_range(0, 3)), !s[0], sides[s], 40);
    end
    run_setting(ssdw_pkg::MODE_CENTRE, 1'b0, 9'd1, 20);
    $display("Sent %0d samples over %0d register settings.", samples_sent, settings_done);
    $display("Covered all sampling modes, both warps and grid sides from 0 to 511.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ssdw_pkg.sv
hdl/stratified_sample_disk_warp.sv
bench/ssdw_checker.sv
bench/tb_top.sv
